>>> src/rrjl_pkg.sv
// ----------------------------------------------------------------------------
// rrjl_pkg: shared types and constants of the round-robin job list
// Op and status codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
package rrjl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int JOB_W     = 16;
    localparam int OCC_W     = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FIN,
        S_NEXT_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [JOB_W-1:0] job;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

>>> src/round_robin_job_list_top.sv
// ----------------------------------------------------------------------------
// round_robin_job_list_top: round-robin job list with removal
// Up to DEPTH 16-bit job ids in arrival order plus a round-robin cursor.
// ----------------------------------------------------------------------------
// Usage
//   s_* : one command item per handshake, op (add / remove / next) + job id.
//   m_* : exactly one result item per command: returned job, status and
//         the occupancy after the command.
// Sequence per command, one command at a time:
//   add          : no RAM read, straight to the result.
//   next         : one RAM read, then the result.
//   remove       : the job RAM is scanned one entry a cycle from the head
//                  up to the hit, then the entries behind it are moved
//                  down one a cycle.
//   unused op    : nothing changes.
// A new command is taken the cycle after the previous result enters the
// output register; a stalled m_tready holds that item and the sequencer
// then waits with its next result until the register frees up.
// Reset clears count and cursor; the RAM needs no clearing, as only data of
// entries below the count is ever used.
// ----------------------------------------------------------------------------
module round_robin_job_list_top #(
    parameter int DEPTH = rrjl_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] op, [17:2] job_id, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] out_job, [17:16] status,
                                   // [22:18] occupancy, [23] zero
);

    import rrjl_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    logic              res_load;
    res_t              res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [JOB_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [JOB_W-1:0]  ram_rdata;

    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg, out_data_next;

    rrjl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[1:0]),
        .in_id     (s_tdata[17:2]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // job store, head at address 0
    rrjl_ram #(
        .WIDTH (JOB_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: free when empty or drained this cycle
    assign res_ready = !out_valid_reg || m_tready;
    assign res_load  = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.occupancy, out_data_reg.status,
                       out_data_reg.job};

    // occupancy never beyond the list size (when it fits in the field)
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (DEPTH > 31) || (32'(m_tdata[22:18]) <= DEPTH))
        else $error("occupancy above DEPTH");

    // full is reported only with a full list
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[17:16] == ST_FULL)) |-> (m_tdata[22:18] == OCC_W'(DEPTH)))
        else $error("full status with list not full");

    // empty is reported only with no jobs held
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[17:16] == ST_EMPTY)) |-> (m_tdata[22:18] == '0))
        else $error("empty status with jobs held");

    // a job is returned only on success
    a_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[17:16] != ST_OK)) |-> (m_tdata[15:0] == '0))
        else $error("job returned with error status");

    // a loaded result shows up at the output next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> m_tvalid)
        else $error("result lost at output register");

endmodule

>>> src/rrjl_ram.sv
// ----------------------------------------------------------------------------
// rrjl_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrjl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rrjl_ctrl.sv
// ----------------------------------------------------------------------------
// rrjl_ctrl: job list sequencer
// Holds count and cursor, runs add / remove / next against the job RAM.
// ----------------------------------------------------------------------------
module rrjl_ctrl #(
    parameter int DEPTH = rrjl_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_op,
    input  logic [rrjl_pkg::JOB_W-1:0]   in_id,
    output logic                         res_valid,
    input  logic                         res_ready,
    output rrjl_pkg::res_t               res,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_waddr,
    output logic [rrjl_pkg::JOB_W-1:0]   ram_wdata,
    output logic [$clog2(DEPTH)-1:0]     ram_raddr,
    input  logic [rrjl_pkg::JOB_W-1:0]   ram_rdata
);

    import rrjl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [AW-1:0] A_ONE  = AW'(1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [JOB_W-1:0]  id_reg, id_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     hit_reg, hit_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    status_t           status_reg, status_next;
    logic              idx_more;

    // another held entry lies behind idx
    assign idx_more = (CW'(idx_reg) + ONE_C) < count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        job_reg    <= job_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        id_next     = id_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        job_next    = job_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = in_id;
        ram_raddr   = cursor_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next     = in_id;
                    job_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (op_t'(in_op))
                        OP_ADD:
                        begin
                            if (count_reg == FULL_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr = cursor_reg;
                                if ((CW'(cursor_reg) + ONE_C) < count_reg)
                                begin
                                    cursor_next = cursor_reg + A_ONE;
                                end
                                else
                                begin
                                    cursor_next = '0;
                                end
                                state_next = S_NEXT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // rdata holds entry idx; the entry after it is read ahead
            S_SEARCH:
            begin
                ram_raddr = idx_reg + A_ONE;
                if (ram_rdata == id_reg)
                begin
                    hit_next = idx_reg;
                    if (idx_more)
                    begin
                        idx_next   = idx_reg + A_ONE;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (idx_more)
                begin
                    idx_next = idx_reg + A_ONE;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            // close the gap: entry idx moves down to idx-1
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - A_ONE;
                ram_wdata = ram_rdata;
                ram_raddr = idx_reg + A_ONE;
                if (idx_more)
                begin
                    idx_next = idx_reg + A_ONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                count_next = count_reg - ONE_C;
                if (count_reg == ONE_C)
                begin
                    cursor_next = '0;
                end
                else if (cursor_reg == hit_reg)
                begin
                    if ((CW'(hit_reg) + ONE_C) >= count_reg)
                    begin
                        cursor_next = '0;
                    end
                end
                else if (cursor_reg > hit_reg)
                begin
                    cursor_next = cursor_reg - A_ONE;
                end
                state_next = S_DONE;
            end

            S_NEXT_RD:
            begin
                job_next   = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.job       = job_reg;
    assign res.status    = status_reg;
    assign res.occupancy = OCC_W'(count_reg);

endmodule
